>>> rtl/utv_pkg.sv
package utv_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned PendW = 2;

  // allowed range of the first continuation byte after a lead
  typedef enum logic [2:0] {
    CLS_ANY = 3'd0,  // 80..BF
    CLS_E0  = 3'd1,  // A0..BF
    CLS_ED  = 3'd2,  // 80..9F
    CLS_F0  = 3'd3,  // 90..BF
    CLS_F4  = 3'd4   // 80..8F
  } cls_e;

  localparam logic [ByteW-1:0] CharTab      = 8'h09;
  localparam logic [ByteW-1:0] CharLf       = 8'h0A;
  localparam logic [ByteW-1:0] CharCr       = 8'h0D;
  localparam logic [ByteW-1:0] CtrlLimit    = 8'h20;
  localparam logic [ByteW-1:0] AsciiMax     = 8'h7F;
  localparam logic [ByteW-1:0] Lead2Lo      = 8'hC2;
  localparam logic [ByteW-1:0] Lead2Hi      = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Lo      = 8'hE0;
  localparam logic [ByteW-1:0] Lead3Hi      = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Lo      = 8'hF0;
  localparam logic [ByteW-1:0] Lead4Hi      = 8'hF4;
  localparam logic [ByteW-1:0] LeadSurr     = 8'hED;
  localparam logic [ByteW-1:0] BoundA0      = 8'hA0;
  localparam logic [ByteW-1:0] Bound90      = 8'h90;
  localparam logic [1:0]       ContTag      = 2'b10;

  typedef struct packed {
    logic [PendW-1:0] pending;
    cls_e             cls;
    logic             err_hit;
  } step_t;

endpackage

>>> rtl/utv_byte_if.sv
interface utv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

>>> rtl/utv_verdict_if.sv
interface utv_verdict_if;
  logic valid;
  logic ready;
  logic is_text;

  modport source (output valid, output is_text, input ready);
  modport sink   (input valid, input is_text, output ready);
endinterface

>>> rtl/utv_byte_classify.sv
module utv_byte_classify (
  input  logic [utv_pkg::ByteW-1:0] byte_i,
  input  logic [utv_pkg::PendW-1:0] pending_i,
  input  utv_pkg::cls_e             cls_i,
  output utv_pkg::step_t            step_o
);
  import utv_pkg::*;

  logic ctrl_bad;
  logic range_ok;
  logic cont_bad;

  always_comb begin
    ctrl_bad = (byte_i < CtrlLimit) && (byte_i != CharTab) &&
               (byte_i != CharLf) && (byte_i != CharCr);
  end

  always_comb begin
    case (cls_i)
      CLS_E0:  range_ok = (byte_i >= BoundA0);
      CLS_ED:  range_ok = (byte_i < BoundA0);
      CLS_F0:  range_ok = (byte_i >= Bound90);
      CLS_F4:  range_ok = (byte_i < Bound90);
      default: range_ok = 1'b1;
    endcase
  end

  assign cont_bad = (byte_i[7:6] != ContTag) || !range_ok;

  always_comb begin
    step_o.pending = '0;
    step_o.cls     = CLS_ANY;
    step_o.err_hit = ctrl_bad;
    if (pending_i != '0) begin
      // a bad continuation still uses up one expected byte
      step_o.pending = pending_i - PendW'(1);
      step_o.err_hit = ctrl_bad | cont_bad;
    end else if (byte_i <= AsciiMax) begin
      step_o.pending = PendW'(0);
    end else if ((byte_i >= Lead2Lo) && (byte_i <= Lead2Hi)) begin
      step_o.pending = PendW'(1);
    end else if ((byte_i >= Lead3Lo) && (byte_i <= Lead3Hi)) begin
      step_o.pending = PendW'(2);
      if (byte_i == Lead3Lo) begin
        step_o.cls = CLS_E0;
      end else if (byte_i == LeadSurr) begin
        step_o.cls = CLS_ED;
      end
    end else if ((byte_i >= Lead4Lo) && (byte_i <= Lead4Hi)) begin
      step_o.pending = PendW'(3);
      if (byte_i == Lead4Lo) begin
        step_o.cls = CLS_F0;
      end else if (byte_i == Lead4Hi) begin
        step_o.cls = CLS_F4;
      end
    end else begin
      // stray continuation, C0/C1 or F5..FF in lead position
      step_o.err_hit = 1'b1;
    end
  end

endmodule

>>> rtl/utf8_text_validator_core.sv
// Checks a byte stream, one byte per item with a last-byte mark, for plain
// UTF-8 text: well-formed sequences (no overlongs, surrogates or code points
// above U+10FFFF) and no control bytes below 0x20 other than tab, LF and CR.
// One verdict item (is_text) is produced per stream, on its last byte; a
// sequence cut off by the last byte fails. A byte is taken every cycle unless
// a last byte is stalled in the input register: each byte is latched there,
// then the one-byte state update runs and, on a last byte, the verdict lands
// in the output register. Only a held verdict whose output is stalled can
// hold back a following last byte, and with it the bytes behind it; other
// bytes keep flowing. State clears after each verdict.
module utf8_text_validator_core (
  input  logic clk_i,
  input  logic rst_ni,
  utv_byte_if.sink      in_i,
  utv_verdict_if.source out_o
);
  import utv_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;

  logic [PendW-1:0] pend_q, pend_d;
  cls_e             cls_q, cls_d;
  logic             err_q, err_d;

  logic out_valid_q, out_valid_d;
  logic is_text_q;

  step_t step;
  logic  out_free;
  logic  s1_go;
  logic  in_take;

  utv_byte_classify u_classify (
    .byte_i    (in_byte_q),
    .pending_i (pend_q),
    .cls_i     (cls_q),
    .step_o    (step)
  );

  assign out_free = !out_valid_q || out_o.ready;
  // only a last byte needs room in the output register
  assign s1_go    = in_valid_q && (!in_last_q || out_free);
  assign in_i.ready = !in_valid_q || s1_go;
  assign in_take  = in_i.valid && in_i.ready;

  always_comb begin
    pend_d = pend_q;
    cls_d  = cls_q;
    err_d  = err_q;
    if (s1_go) begin
      if (in_last_q) begin
        pend_d = '0;
        cls_d  = CLS_ANY;
        err_d  = 1'b0;
      end else begin
        pend_d = step.pending;
        cls_d  = step.cls;
        err_d  = err_q | step.err_hit;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (s1_go && in_last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      pend_q      <= '0;
      cls_q       <= CLS_ANY;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (s1_go) begin
        in_valid_q <= 1'b0;
      end
      pend_q      <= pend_d;
      cls_q       <= cls_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.byte_value;
      in_last_q <= in_i.last_byte;
    end
    if (s1_go && in_last_q) begin
      is_text_q <= !(err_q | step.err_hit) && (step.pending == '0);
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.is_text = is_text_q;

endmodule
